[src/pwns_pkg.sv]
package pwns_pkg;

   // Largest number of words of one section that are evaluated.
   localparam int MAX_WORDS = 4096;

   // Field widths.
   localparam int FRAME_W  = 32;
   localparam int PAD_W    = 16;
   localparam int OFFSET_W = 32;
   localparam int INDEX_W  = 12;
   localparam int GAP_W    = 34;

   // Width of the internal signed frame arithmetic. It holds every shifted, padded
   // and guarded bound without wrapping.
   localparam int CALC_W = 36;

   // The word counter must reach MAX_WORDS and must also supply a full result index.
   localparam int CNT_W = ($clog2(MAX_WORDS + 1) > INDEX_W) ?
                          $clog2(MAX_WORDS + 1) : INDEX_W;

   // One frame of guard on each side of the padded interval.
   localparam int EDGE_GUARD_FRAMES = 1;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_PREPEND  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POSTPEND = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET   = 2'd2;

   typedef logic [FRAME_W-1:0]         frame_type;
   typedef logic [PAD_W-1:0]           pad_type;
   typedef logic signed [OFFSET_W-1:0] offset_type;
   typedef logic [INDEX_W-1:0]         index_type;
   typedef logic [GAP_W-1:0]           gap_type;
   typedef logic [CNT_W-1:0]           count_type;
   typedef logic signed [CALC_W-1:0]   calc_type;

   // Bounds of one word after the shift, held between the input register and
   // the running-best update.
   typedef struct packed {
      calc_type query;        // query frame, zero extended
      calc_type shift_start;  // word_start + offset
      calc_type shift_end;    // word_end + offset
      calc_type guard_lo;     // shifted start - prepend - guard, before the clamp at zero
      calc_type guard_hi_end; // shifted end + postpend + guard
      calc_type guard_hi_beg; // shifted start - prepend + guard, before the clamp at zero
      logic     last;
   } word_calc_type;

endpackage

[src/pwns_req_if.sv]
interface pwns_req_if;

   logic                valid;
   logic                ready;
   pwns_pkg::frame_type query_frame;
   pwns_pkg::frame_type word_start;
   pwns_pkg::frame_type word_end;
   logic                last_word;

   modport source (
      output valid,
      input  ready,
      output query_frame,
      output word_start,
      output word_end,
      output last_word
   );

   modport sink (
      input  valid,
      output ready,
      input  query_frame,
      input  word_start,
      input  word_end,
      input  last_word
   );

endinterface

[src/pwns_rsp_if.sv]
interface pwns_rsp_if;

   logic                valid;
   logic                ready;
   logic                found;
   pwns_pkg::index_type word_index;

   modport source (
      output valid,
      input  ready,
      output found,
      output word_index
   );

   modport sink (
      input  valid,
      output ready,
      input  found,
      input  word_index
   );

endinterface

[src/padded_word_nearest_search.sv]
// Nearest-word search over one section. The words of a section arrive on req_ch
// as start and end frame pairs, each with the query frame, and the final word is
// marked by last_word. Every word is shifted by the signed offset register, widened
// by the prepend and postpend registers, clamped at frame zero and guarded by one
// frame on each side; a word whose guarded interval misses the query is skipped.
// Among the words that remain, the one nearest the query (measured from its shifted,
// unpadded interval) is kept, and on a tie the later word wins when the query lies at
// or past its shifted start. One transfer on rsp_ch follows each last word and gives
// found and the word's position in the section (zero when nothing matched). The block
// takes one word per clock cycle unless stalled: a word passes through the input
// register, where its shifted bounds are formed, and is then compared and folded into
// the running best, with the result registered as its last word leaves the input
// register. The only stall comes from the result register: a last word waits in the input
// register while an earlier result has not yet been taken. Words beyond MAX_WORDS in
// one section are not evaluated, though their last_word mark still closes the search.
// Configuration writes on the csr_ port should only be made while no search is in
// progress.
module padded_word_nearest_search (
   input  logic                                 clock,
   input  logic                                 reset,

   pwns_req_if.sink                             req_ch,
   pwns_rsp_if.source                           rsp_ch,

   input  logic                                 csr_we,
   input  logic [pwns_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pwns_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int ZEXT_FRAME_W = pwns_pkg::CALC_W - pwns_pkg::FRAME_W;
   localparam int ZEXT_PAD_W   = pwns_pkg::CALC_W - pwns_pkg::PAD_W;

   // Configuration registers.
   pwns_pkg::pad_type    prepend_ff;
   pwns_pkg::pad_type    postpend_ff;
   pwns_pkg::offset_type offset_ff;

   // Input register stage.
   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   pwns_pkg::word_calc_type s1_ff;
   pwns_pkg::word_calc_type s1_in;

   // Running search state.
   pwns_pkg::count_type word_counter_ff;
   pwns_pkg::count_type word_counter_in;
   pwns_pkg::index_type best_position_ff;
   pwns_pkg::index_type best_position_in;
   pwns_pkg::gap_type   best_gap_ff;
   pwns_pkg::gap_type   best_gap_in;
   logic                have_best_ff;
   logic                have_best_in;

   // Result register.
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                found_ff;
   logic                found_in;
   pwns_pkg::index_type word_index_ff;
   pwns_pkg::index_type word_index_in;

   // Handshake and evaluation signals.
   logic                req_accept;
   logic                out_free;
   logic                s1_fire;
   logic                evaluate;
   logic                covers;
   logic                take;
   pwns_pkg::calc_type  offset_ext;
   pwns_pkg::calc_type  prepend_ext;
   pwns_pkg::calc_type  postpend_ext;
   pwns_pkg::calc_type  guard_ext;
   pwns_pkg::calc_type  distance;
   pwns_pkg::gap_type   gap;
   pwns_pkg::index_type next_position;
   logic                next_have;

   // ------------------------------------------------------------------------
   // Configuration port.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         prepend_ff  <= '0;
         postpend_ff <= '0;
         offset_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            pwns_pkg::CSR_PREPEND: begin
               prepend_ff <= csr_wdata[pwns_pkg::PAD_W-1:0];
            end
            pwns_pkg::CSR_POSTPEND: begin
               postpend_ff <= csr_wdata[pwns_pkg::PAD_W-1:0];
            end
            pwns_pkg::CSR_OFFSET: begin
               offset_ff <= pwns_pkg::offset_type'(csr_wdata[pwns_pkg::OFFSET_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Flow control. A word leaves the input register every cycle unless it is a
   // last word and the result register still holds a result that has not been
   // taken. The input register refills in the same cycle it empties.
   // ------------------------------------------------------------------------
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_fire      = s1_valid_ff && (!s1_ff.last || out_free);
   assign req_ch.ready = !s1_valid_ff || s1_fire;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // ------------------------------------------------------------------------
   // Input stage: shift the word by the offset and form the padded, guarded
   // bounds before any clamping. The clamps at zero are folded into the
   // comparisons of the next stage: the query is never negative, so a negative
   // lower bound passes any query, and a negative padded start turns the upper
   // bound into the guard frame alone.
   // ------------------------------------------------------------------------
   assign offset_ext   = pwns_pkg::calc_type'(offset_ff);
   assign prepend_ext  = $signed({{ZEXT_PAD_W{1'b0}}, prepend_ff});
   assign postpend_ext = $signed({{ZEXT_PAD_W{1'b0}}, postpend_ff});
   assign guard_ext    = pwns_pkg::calc_type'(pwns_pkg::EDGE_GUARD_FRAMES);

   always_comb begin
      s1_in.query        = $signed({{ZEXT_FRAME_W{1'b0}}, req_ch.query_frame});
      s1_in.shift_start  = $signed({{ZEXT_FRAME_W{1'b0}}, req_ch.word_start}) + offset_ext;
      s1_in.shift_end    = $signed({{ZEXT_FRAME_W{1'b0}}, req_ch.word_end}) + offset_ext;
      s1_in.guard_lo     = s1_in.shift_start - prepend_ext - guard_ext;
      s1_in.guard_hi_end = s1_in.shift_end + postpend_ext + guard_ext;
      s1_in.guard_hi_beg = s1_in.shift_start - prepend_ext + guard_ext;
      s1_in.last         = req_ch.last_word;
   end

   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
   end

   // ------------------------------------------------------------------------
   // Evaluation stage: check that the guarded interval covers the query,
   // measure the distance to the shifted word and update the running best.
   // ------------------------------------------------------------------------
   assign evaluate = s1_fire &&
                     (word_counter_ff < pwns_pkg::count_type'(pwns_pkg::MAX_WORDS));

   assign covers = (s1_ff.query >= s1_ff.guard_lo) &&
                   ((s1_ff.query <= s1_ff.guard_hi_end) ||
                    (s1_ff.query <= s1_ff.guard_hi_beg) ||
                    (s1_ff.query <= guard_ext));

   always_comb begin
      if (s1_ff.query < s1_ff.shift_start) begin
         distance = s1_ff.shift_start - s1_ff.query;
      end else if (s1_ff.query > s1_ff.shift_end) begin
         distance = s1_ff.query - s1_ff.shift_end;
      end else begin
         distance = '0;
      end
   end

   assign gap = distance[pwns_pkg::GAP_W-1:0];

   // A tie moves the best to this later word only when the query is at or past
   // its shifted start.
   assign take = evaluate && covers &&
                 ((gap < best_gap_ff) ||
                  ((gap == best_gap_ff) && have_best_ff &&
                   (s1_ff.query >= s1_ff.shift_start)));

   assign next_position = take ? word_counter_ff[pwns_pkg::INDEX_W-1:0] : best_position_ff;
   assign next_have     = take || have_best_ff;

   always_comb begin
      word_counter_in  = word_counter_ff;
      best_position_in = best_position_ff;
      best_gap_in      = best_gap_ff;
      have_best_in     = have_best_ff;
      if (s1_fire) begin
         if (s1_ff.last) begin
            // The search ends here; the next word opens a new section.
            word_counter_in  = '0;
            best_position_in = '0;
            best_gap_in      = '1;
            have_best_in     = 1'b0;
         end else begin
            if (evaluate) begin
               word_counter_in = word_counter_ff + pwns_pkg::count_type'(1);
            end
            if (take) begin
               best_position_in = next_position;
               best_gap_in      = gap;
               have_best_in     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_counter_ff  <= '0;
         best_position_ff <= '0;
         best_gap_ff      <= '1;
         have_best_ff     <= 1'b0;
      end else begin
         word_counter_ff  <= word_counter_in;
         best_position_ff <= best_position_in;
         best_gap_ff      <= best_gap_in;
         have_best_ff     <= have_best_in;
      end
   end

   // ------------------------------------------------------------------------
   // Result register. The last word's own outcome is included in the result.
   // ------------------------------------------------------------------------
   assign rsp_valid_in  = (s1_fire && s1_ff.last) || (rsp_valid_ff && !rsp_ch.ready);
   assign found_in      = next_have;
   assign word_index_in = next_have ? next_position : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_ff.last) begin
         found_ff      <= found_in;
         word_index_ff <= word_index_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.found      = found_ff;
   assign rsp_ch.word_index = word_index_ff;

endmodule

[bench/nearest_search_checker.sv]
`timescale 1ns / 100ps

module nearest_search_checker
   import pwns_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   pwns_req_if                    req_ch,
   pwns_rsp_if                    rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatches,
   output int                     outstanding,
   output int                     answers_seen,
   output int                     words_seen
);

   typedef struct packed {
      logic      found;
      index_type word_index;
   } answer_type;

   // Answers predicted for closed sections, oldest first.
   answer_type search_answers[$];

   pad_type    prepend_reg;
   pad_type    postpend_reg;
   offset_type offset_reg;

   int        word_count;
   index_type best_word;
   gap_type   best_gap;
   logic      have_best;

   int error_tally  = 0;
   int answer_tally = 0;
   int word_tally   = 0;

   task automatic restart_search();
      word_count = 0;
      best_word  = '0;
      best_gap   = '1;
      have_best  = 1'b0;
   endtask

   // Folds one word into the running best of the current section.
   task automatic fold_word(input frame_type query_frame, input frame_type start_frame,
                            input frame_type end_frame);
      calc_type query;
      calc_type off_x;
      calc_type sh_start;
      calc_type sh_end;
      calc_type pad_lo;
      calc_type pad_hi;
      calc_type guard_lo;
      calc_type guard_hi;
      calc_type diff;
      gap_type  gap;
      query    = calc_type'(query_frame);
      off_x    = calc_type'(offset_reg);
      sh_start = calc_type'(start_frame) + off_x;
      sh_end   = calc_type'(end_frame) + off_x;
      pad_lo   = sh_start - calc_type'(prepend_reg);
      pad_hi   = sh_end + calc_type'(postpend_reg);
      if (pad_lo < 0) begin
         pad_lo = 0;
      end
      if (pad_hi < pad_lo) begin
         pad_hi = pad_lo;
      end
      guard_lo = pad_lo - EDGE_GUARD_FRAMES;
      if (guard_lo < 0) begin
         guard_lo = 0;
      end
      guard_hi = pad_hi + EDGE_GUARD_FRAMES;
      if (query < guard_lo || query > guard_hi) begin
         return;
      end
      if (query < sh_start) begin
         diff = sh_start - query;
      end else if (query > sh_end) begin
         diff = query - sh_end;
      end else begin
         diff = 0;
      end
      gap = diff[GAP_W-1:0];
      if (gap < best_gap || (gap == best_gap && have_best && query >= sh_start)) begin
         best_word = word_count[INDEX_W-1:0];
         best_gap  = gap;
         have_best = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         prepend_reg  = '0;
         postpend_reg = '0;
         offset_reg   = '0;
         search_answers.delete();
         restart_search();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PREPEND: begin
                  prepend_reg = csr_wdata[PAD_W-1:0];
               end
               CSR_POSTPEND: begin
                  postpend_reg = csr_wdata[PAD_W-1:0];
               end
               CSR_OFFSET: begin
                  offset_reg = csr_wdata[OFFSET_W-1:0];
               end
               default: begin
               end
            endcase
         end

         // Results are matched before this edge's word is folded in, so a result can
         // never be paired with the section that closes on the same edge.
         if (rsp_ch.valid && rsp_ch.ready) begin
            answer_tally++;
            if (search_answers.size() == 0) begin
               $display("%0t: result transfer with no answer waiting: found %0b index %0d",
                        $time, rsp_ch.found, rsp_ch.word_index);
               error_tally++;
            end else begin
               want = search_answers.pop_front();
               if (rsp_ch.found !== want.found) begin
                  $display("%0t: found mismatch: expected %0b, actual %0b",
                           $time, want.found, rsp_ch.found);
                  error_tally++;
               end
               if (rsp_ch.word_index !== want.word_index) begin
                  $display("%0t: word_index mismatch: expected %0d, actual %0d",
                           $time, want.word_index, rsp_ch.word_index);
                  error_tally++;
               end
            end
         end

         if (req_ch.valid && req_ch.ready) begin
            word_tally++;
            if (word_count < MAX_WORDS) begin
               fold_word(req_ch.query_frame, req_ch.word_start, req_ch.word_end);
               word_count++;
            end
            if (req_ch.last_word) begin
               want.found      = have_best;
               want.word_index = have_best ? best_word : '0;
               search_answers  = {search_answers, want};
               restart_search();
            end
         end
      end
      mismatches   <= error_tally;
      outstanding  <= search_answers.size();
      answers_seen <= answer_tally;
      words_seen   <= word_tally;
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the nearest-word search. The checker beside the block
// predicts every section's answer; this module only produces sections, register
// settings and back-pressure, and reports the outcome.
module tb;
   import pwns_pkg::*;

   // Random words to send after the directed part.
   localparam int RANDOM_WORDS = 1500;

   logic clock = 1'b0;
   logic reset;

   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatches;
   int outstanding;
   int answers_seen;
   int words_seen;

   // While set, neither side idles, so the block runs at its full rate.
   bit steady_flow = 1'b0;

   int     random_words  = 0;
   int     setting_count = 0;
   int     cfg_pre       = 0;
   int     cfg_post      = 0;
   longint cfg_off       = 0;

   pwns_req_if req_ch ();
   pwns_rsp_if rsp_ch ();

   padded_word_nearest_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   nearest_search_checker search_check (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .answers_seen (answers_seen),
      .words_seen   (words_seen)
   );

   always #2 clock = ~clock;

   // Hard stop in case the block hangs on either channel.
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Idle cycles that one side inserts ahead of its next transfer.
   function automatic int idle_gap();
      if (steady_flow) begin
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   function automatic frame_type clamp_frame(input longint v);
      if (v < 0) begin
         return '0;
      end
      if (v > 64'd4294967295) begin
         return '1;
      end
      return v[FRAME_W-1:0];
   endfunction

   // Frames near both ends of the range show up often, so the clamps get exercised.
   function automatic frame_type pick_frame();
      case ($urandom_range(0, 5))
         0: begin
            return frame_type'($urandom_range(0, 50));
         end
         1: begin
            return 32'hFFFF_FFFF - frame_type'($urandom_range(0, 50));
         end
         default: begin
            return frame_type'($urandom);
         end
      endcase
   endfunction

   function automatic pad_type pick_pad();
      case ($urandom_range(0, 5))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2, 3: begin
            return pad_type'($urandom_range(0, 20));
         end
         default: begin
            return pad_type'($urandom_range(0, 65535));
         end
      endcase
   endfunction

   function automatic offset_type pick_offset();
      case ($urandom_range(0, 6))
         0: begin
            return '0;
         end
         1: begin
            return 32'sh8000_0000;
         end
         2: begin
            return 32'sh7FFF_FFFF;
         end
         3, 4: begin
            return offset_type'($urandom_range(0, 200)) - 100;
         end
         default: begin
            return offset_type'($urandom);
         end
      endcase
   endfunction

   // Offers one word and returns at the edge of its transfer, with valid still high
   // so that a back-to-back word keeps the channel busy.
   task automatic send_word(input frame_type query_frame, input frame_type start_frame,
                            input frame_type end_frame, input logic is_last);
      int gap;
      gap = idle_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.query_frame <= query_frame;
      req_ch.word_start  <= start_frame;
      req_ch.word_end    <= end_frame;
      req_ch.last_word   <= is_last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Holds the sender off until every predicted answer has come back, then lets the
   // pipeline settle so the registers can be rewritten safely.
   task automatic drain_searches();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   // Writes all three registers on consecutive edges; called only while the block
   // is idle.
   task automatic set_config(input pad_type pre, input pad_type post, input offset_type off);
      csr_we    <= 1'b1;
      csr_index <= CSR_PREPEND;
      csr_wdata <= CSR_DATA_W'(pre);
      @(posedge clock);
      csr_index <= CSR_POSTPEND;
      csr_wdata <= CSR_DATA_W'(post);
      @(posedge clock);
      csr_index <= CSR_OFFSET;
      csr_wdata <= CSR_DATA_W'(off);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_pre  = int'(pre);
      cfg_post = int'(post);
      cfg_off  = longint'(off);
      setting_count++;
   endtask

   // One section of random words. Most words are placed around a common center so
   // that their shifted intervals land near the query and compete for the best;
   // a few are reversed, and a few are pure noise.
   task automatic run_section(input int word_total);
      longint    center;
      longint    spread;
      longint    lo;
      longint    hi;
      frame_type query;
      frame_type word_query;
      frame_type start_frame;
      frame_type end_frame;
      int        kind;
      center = longint'(pick_frame());
      spread = 40 + (cfg_pre + cfg_post) / 4;
      if (spread > 5000) begin
         spread = 5000;
      end
      query = clamp_frame(center + cfg_off + longint'($urandom_range(0, 60)) - 30);
      for (int i = 0; i < word_total; i++) begin
         kind       = $urandom_range(0, 19);
         word_query = query;
         if (kind <= 1) begin
            start_frame = frame_type'($urandom);
            end_frame   = frame_type'($urandom);
            if (kind == 1) begin
               word_query = frame_type'($urandom);
            end
         end else begin
            lo = center + longint'($urandom_range(0, 2 * spread)) - spread;
            if (kind == 2) begin
               hi = lo - longint'($urandom_range(1, 30));
            end else begin
               hi = lo + longint'($urandom_range(0, 30));
            end
            start_frame = clamp_frame(lo);
            end_frame   = clamp_frame(hi);
         end
         send_word(word_query, start_frame, end_frame, i == word_total - 1);
         random_words++;
      end
   endtask

   // Result side: after each result appears it may hold ready low for a drawn number
   // of cycles before accepting the transfer.
   initial begin : result_side
      int stall;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_gap();
         if (stall == 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b0;
            do @(posedge clock); while (!rsp_ch.valid);
            repeat (stall - 1) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin : word_side
      int phase_end;
      int section_len;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_PREPEND;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.query_frame = '0;
      req_ch.word_start  = '0;
      req_ch.word_end    = '0;
      req_ch.last_word   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // With the registers at their reset values: a miss, a nearer word, a tie that
      // stays because the query is before the new word, an exact hit, and a tie that
      // moves because the query is at or past the later word's start.
      send_word(32'd100, 32'd200, 32'd300, 1'b0);
      send_word(32'd100, 32'd90, 32'd99, 1'b0);
      send_word(32'd100, 32'd101, 32'd110, 1'b0);
      send_word(32'd100, 32'd100, 32'd100, 1'b0);
      send_word(32'd100, 32'd95, 32'd100, 1'b1);
      // A section where nothing matches, then one at frame zero where the guard
      // start is clamped.
      send_word(32'd0, 32'd5, 32'd6, 1'b1);
      send_word(32'd0, 32'd0, 32'd0, 1'b1);
      // Largest frames, with an end before its start.
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0);
      send_word(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1);

      // Widest padding and the most negative shift: the padded start goes below zero
      // and the padded end is clamped up to it.
      drain_searches();
      set_config('1, '1, 32'sh8000_0000);
      send_word(32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_word(32'd5, 32'h8000_0003, 32'h8000_0004, 1'b0);
      send_word(32'd5, 32'h8000_0000, 32'h8000_0000, 1'b1);
      send_word(32'd0, 32'd0, 32'd0, 1'b1);

      // Largest positive shift pushes bounds past the 32-bit range.
      drain_searches();
      set_config('0, '0, 32'sh7FFF_FFFF);
      send_word(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 32'h8000_0001, 32'h8000_0001, 1'b1);
      send_word(32'd0, 32'd0, 32'd0, 1'b1);

      // Small pads with a small negative shift; only the padding brings the last
      // word within reach of the query.
      drain_searches();
      set_config(16'd2, 16'd3, -32'sd2);
      send_word(32'd10, 32'd14, 32'd20, 1'b0);
      send_word(32'd10, 32'd4, 32'd6, 1'b0);
      send_word(32'd10, 32'd3, 32'd9, 1'b1);

      // Random phases, each with its own register setting and flow mode. Every phase
      // boundary holds the sender until all answers are back.
      while (random_words < RANDOM_WORDS) begin
         drain_searches();
         set_config(pick_pad(), pick_pad(), pick_offset());
         steady_flow = ($urandom_range(0, 3) == 0);
         phase_end   = random_words + $urandom_range(60, 240);
         while (random_words < phase_end) begin
            if ($urandom_range(0, 7) == 0) begin
               section_len = $urandom_range(1, 40);
            end else begin
               section_len = $urandom_range(1, 8);
            end
            run_section(section_len);
         end
      end
      steady_flow = 1'b0;
      drain_searches();

      $display("Sent %0d words (%0d random) and checked %0d section answers",
               words_seen, random_words, answers_seen);
      $display("across %0d register settings, with idle and full-rate phases.",
               setting_count);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[filelist.f]
src/pwns_pkg.sv
src/pwns_req_if.sv
src/pwns_rsp_if.sv
src/padded_word_nearest_search.sv
bench/nearest_search_checker.sv
bench/tb.sv
